// ===== rtl/mma_pkg.sv =====
package mma_pkg;

  // Store depths and index widths
  localparam int unsigned DATA_WORDS = 4096;
  localparam int unsigned INST_WORDS = 4096;
  localparam int unsigned DATA_AW    = $clog2(DATA_WORDS);
  localparam int unsigned INST_AW    = $clog2(INST_WORDS);
  localparam int unsigned CLR_WORDS  = (DATA_WORDS > INST_WORDS) ? DATA_WORDS : INST_WORDS;
  localparam int unsigned CLR_AW     = $clog2(CLR_WORDS);

  // Address map
  localparam logic [31:0] DATA_BASE    = 32'h2000_0000;
  localparam logic [31:0] DATA_END     = 32'h2400_0000;
  localparam logic [31:0] INST_BASE    = 32'h1000_0000;
  localparam logic [31:0] INST_END     = 32'h1100_0000;
  localparam logic [31:0] CON_IN_ADDR  = 32'h3000_0000;
  localparam logic [31:0] CON_OUT_ADDR = 32'h3000_0004;

  // Access codes
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_FETCH = 2'd2;
  localparam logic [1:0] ACT_LOAD  = 2'd3;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_BAD   = 2'd1;
  localparam logic [1:0] STAT_DEPTH = 2'd2;

  // Store operation of one access
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_DATA_RD = 3'd1,
    OP_INST_RD = 3'd2,
    OP_DATA_WR = 3'd3,
    OP_INST_WR = 3'd4
  } op_t;

  // Decoded access
  typedef struct packed {
    op_t                op;
    logic [DATA_AW-1:0] data_idx;
    logic [INST_AW-1:0] inst_idx;
    logic [4:0]         shift;
    logic [31:0]        lmask;
    logic [31:0]        wdata;
    logic [31:0]        rd;
    logic               cv;
    logic [7:0]         co;
    logic               cc;
    logic [1:0]         st;
  } dec_t;

  // Store port request
  typedef struct packed {
    logic               d_re;
    logic               d_we;
    logic [DATA_AW-1:0] d_addr;
    logic [31:0]        d_wdata;
    logic               i_re;
    logic               i_we;
    logic [INST_AW-1:0] i_addr;
    logic [31:0]        i_wdata;
  } mem_req_t;

endpackage

// ===== rtl/mma_decode.sv =====
module mma_decode (
  input  logic [1:0]   action,
  input  logic [1:0]   access_size,
  input  logic [31:0]  address,
  input  logic [31:0]  write_data,
  input  logic [7:0]   console_char,
  input  logic         console_eof,
  output mma_pkg::dec_t dec
);
  import mma_pkg::*;

  logic        data_hit;
  logic        inst_hit;
  logic        data_deep;
  logic        inst_deep;
  logic        is_write;
  logic        misaligned;
  logic        low_lane;
  logic [4:0]  shift;
  logic [31:0] lmask;

  // Decode regions and depth limits
  assign data_hit  = (address >= DATA_BASE) && (address < DATA_END);
  assign inst_hit  = (address >= INST_BASE) && (address < INST_END);
  assign data_deep = 32'(address[25:2]) >= 32'(DATA_WORDS);
  assign inst_deep = 32'(address[23:2]) >= 32'(INST_WORDS);
  assign is_write  = (action == ACT_WRITE);

  // Derive big-endian lane position, mask and alignment from the size
  always_comb begin
    shift      = 5'd0;
    lmask      = 32'hFFFF_FFFF;
    low_lane   = 1'b1;
    misaligned = 1'b0;
    unique case (access_size)
      SZ_BYTE: begin
        shift    = {~address[1:0], 3'b000};
        lmask    = 32'h0000_00FF;
        low_lane = (address[1:0] == 2'b11);
      end
      SZ_HALF: begin
        shift      = {~address[1], 4'b0000};
        lmask      = 32'h0000_FFFF;
        low_lane   = address[1];
        misaligned = address[0];
      end
      SZ_WORD: begin
        misaligned = (address[1:0] != 2'b00);
      end
      default: begin
        misaligned = 1'b1;
      end
    endcase
  end

  // Classify the access and settle fixed results
  always_comb begin
    dec.op       = OP_NONE;
    dec.data_idx = address[DATA_AW+1:2];
    dec.inst_idx = address[INST_AW+1:2];
    dec.shift    = shift;
    dec.lmask    = lmask;
    dec.wdata    = write_data & lmask;
    dec.rd       = 32'd0;
    dec.cv       = 1'b0;
    dec.co       = 8'd0;
    dec.cc       = 1'b0;
    dec.st       = STAT_OK;
    if (action == ACT_FETCH || action == ACT_LOAD) begin
      dec.shift = 5'd0;
      dec.lmask = 32'hFFFF_FFFF;
      dec.wdata = write_data;
      priority if (!inst_hit || address[1:0] != 2'b00) begin
        dec.st = STAT_BAD;
      end else if (inst_deep) begin
        dec.st = STAT_DEPTH;
      end else begin
        dec.op = (action == ACT_FETCH) ? OP_INST_RD : OP_INST_WR;
      end
      if (action == ACT_FETCH && dec.st != STAT_OK) begin
        dec.rd = 32'hFFFF_FFFF;
      end
    end else begin
      priority if (misaligned) begin
        dec.st = STAT_BAD;
      end else if (data_hit || (inst_hit && !is_write)) begin
        if (data_hit ? data_deep : inst_deep) begin
          dec.st = STAT_DEPTH;
        end else if (is_write) begin
          dec.op = OP_DATA_WR;
        end else begin
          dec.op = data_hit ? OP_DATA_RD : OP_INST_RD;
        end
      end else if (!is_write && address[31:2] == CON_IN_ADDR[31:2]) begin
        if (console_eof) begin
          dec.rd = lmask;
        end else begin
          dec.cc = 1'b1;
          dec.rd = low_lane ? {24'd0, console_char} : 32'd0;
        end
      end else if (is_write && address[31:2] == CON_OUT_ADDR[31:2]) begin
        dec.cv = 1'b1;
        dec.co = low_lane ? write_data[7:0] : 8'd0;
      end else begin
        dec.st = STAT_BAD;
      end
    end
  end

endmodule

// ===== rtl/mma_store.sv =====
module mma_store (
  input  logic              clk,
  input  logic              rst_n,
  input  mma_pkg::mem_req_t req,
  output logic [31:0]       d_rdata,
  output logic [31:0]       i_rdata,
  output logic              clr_busy
);
  import mma_pkg::*;

  logic [31:0]       dmem [DATA_WORDS];
  logic [31:0]       imem [INST_WORDS];
  logic [CLR_AW-1:0] clr_cnt_r;
  logic [CLR_AW-1:0] clr_cnt_nxt;
  logic              clr_busy_r;
  logic              clr_busy_nxt;
  logic [31:0]       d_rdata_r;
  logic [31:0]       i_rdata_r;

  // Sweep both stores once after reset
  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == CLR_AW'(CLR_WORDS - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_cnt_r  <= clr_cnt_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  // Data store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (clr_busy_r && (32'(clr_cnt_r) < 32'(DATA_WORDS))) begin
      dmem[clr_cnt_r[DATA_AW-1:0]] <= 32'd0;
    end else if (req.d_we) begin
      dmem[req.d_addr] <= req.d_wdata;
    end
    if (req.d_re) begin
      d_rdata_r <= dmem[req.d_addr];
    end
  end

  // Instruction store: same port structure
  always_ff @(posedge clk) begin
    if (clr_busy_r && (32'(clr_cnt_r) < 32'(INST_WORDS))) begin
      imem[clr_cnt_r[INST_AW-1:0]] <= 32'd0;
    end else if (req.i_we) begin
      imem[req.i_addr] <= req.i_wdata;
    end
    if (req.i_re) begin
      i_rdata_r <= imem[req.i_addr];
    end
  end

  assign d_rdata  = d_rdata_r;
  assign i_rdata  = i_rdata_r;
  assign clr_busy = clr_busy_r;

endmodule

// ===== rtl/mips_memory_map_access.sv =====
// Result: registered out in execute, after its beat is accepted. Beats are
//   taken only in idle with the result slot free; the store read at accept
//   and the read-modify-write or result capture in execute share one port.
// Reset: synchronous, active low; then a clearing pass zeroes both
//   stores, with in_ready low until it completes.
module mips_memory_map_access (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [1:0]  in_access_size,
  input  logic [31:0] in_address,
  input  logic [31:0] in_write_data,
  input  logic [7:0]  in_console_char,
  input  logic        in_console_eof,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic        out_char_out_valid,
  output logic [7:0]  out_char_out,
  output logic        out_char_consumed,
  output logic [1:0]  out_status
);
  import mma_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t      state_r;
  state_t      state_nxt;
  dec_t        dec;
  dec_t        dec_r;
  mem_req_t    req;
  logic [31:0] d_rdata;
  logic [31:0] i_rdata;
  logic        clr_busy;
  logic        accept;
  logic        exec;
  logic [31:0] word;
  logic [31:0] lane_data;
  logic [31:0] merged;

  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] out_read_data_r;
  logic        out_char_out_valid_r;
  logic [7:0]  out_char_out_r;
  logic        out_char_consumed_r;
  logic [1:0]  out_status_r;

  mma_decode u_decode (
    .action       (in_action),
    .access_size  (in_access_size),
    .address      (in_address),
    .write_data   (in_write_data),
    .console_char (in_console_char),
    .console_eof  (in_console_eof),
    .dec          (dec)
  );

  mma_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .d_rdata  (d_rdata),
    .i_rdata  (i_rdata),
    .clr_busy (clr_busy)
  );

  // Take a beat when idle and the result slot will be free
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign exec     = (state_r == ST_EXEC);

  // Sequence clear, accept and execute
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (!clr_busy) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the decoded access for the execute cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      dec_r <= dec;
    end
  end

  // Read at accept, write back in execute
  always_comb begin
    req.d_re    = accept && (dec.op == OP_DATA_RD || dec.op == OP_DATA_WR);
    req.d_we    = exec && (dec_r.op == OP_DATA_WR);
    req.d_addr  = exec ? dec_r.data_idx : dec.data_idx;
    req.d_wdata = merged;
    req.i_re    = accept && (dec.op == OP_INST_RD);
    req.i_we    = exec && (dec_r.op == OP_INST_WR);
    req.i_addr  = exec ? dec_r.inst_idx : dec.inst_idx;
    req.i_wdata = dec_r.wdata;
  end

  // Extract the read lane and merge the write lane
  assign word      = (dec_r.op == OP_INST_RD) ? i_rdata : d_rdata;
  assign lane_data = (word >> dec_r.shift) & dec_r.lmask;
  assign merged    = (d_rdata & ~(dec_r.lmask << dec_r.shift)) |
                     (dec_r.wdata << dec_r.shift);

  // Output register: load in execute, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_read_data_r      <= (dec_r.op == OP_DATA_RD || dec_r.op == OP_INST_RD) ?
                              lane_data : dec_r.rd;
      out_char_out_valid_r <= dec_r.cv;
      out_char_out_r       <= dec_r.co;
      out_char_consumed_r  <= dec_r.cc;
      out_status_r         <= dec_r.st;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_read_data_r;
  assign out_char_out_valid = out_char_out_valid_r;
  assign out_char_out       = out_char_out_r;
  assign out_char_consumed  = out_char_consumed_r;
  assign out_status         = out_status_r;

`ifndef ASSERT_OFF
  // An accepted beat always moves into execute
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC))
    else $error("accepted beat did not enter execute");

  // Execute always leaves a result waiting
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_valid_r)
    else $error("execute left no result");

  // No beat is taken while the stores are still clearing
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !accept)
    else $error("beat accepted during clearing pass");

  // A console character out and a console read never share a result
  a_console_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_char_out_valid_r && out_char_consumed_r))
    else $error("console read and write in one result");
`endif

endmodule

// ===== dv/mma_tb_pkg.sv =====
`timescale 1ns / 1ps
package mma_tb_pkg;
  import mma_pkg::*;

  // Access size with no meaning on a read or write
  localparam logic [1:0] SZ_NONE = 2'd3;

  // One access beat as offered on the input side
  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  size;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [7:0]  cons_char;
    logic        cons_eof;
  } access_t;

  // One reply beat
  typedef struct packed {
    logic [31:0] rdata;
    logic        char_valid;
    logic [7:0]  char_byte;
    logic        char_taken;
    logic [1:0]  status;
  } reply_t;

  class access_scoreboard;
    logic [31:0] data_mem [DATA_WORDS];
    logic [31:0] inst_mem [INST_WORDS];
    reply_t      due_replies [$];
    int unsigned error_count;

    function new();
      foreach (data_mem[i]) data_mem[i] = '0;
      foreach (inst_mem[i]) inst_mem[i] = '0;
      error_count = 0;
    endfunction

    // Decode one access against the memory map and apply its store update
    function reply_t map_access(access_t acc);
      reply_t      r;
      logic [31:0] idx;
      logic [31:0] depth;
      logic [31:0] lmask;
      logic [31:0] word;
      int unsigned nbytes;
      int unsigned shift;
      logic        hit_data;
      logic        hit_inst;
      logic        is_wr;
      logic        low_lane;
      r = '0;
      hit_data = (acc.addr >= DATA_BASE) && (acc.addr < DATA_END);
      hit_inst = (acc.addr >= INST_BASE) && (acc.addr < INST_END);
      if (acc.action == ACT_FETCH || acc.action == ACT_LOAD) begin
        // fetch and load always work on whole instruction words
        idx = (acc.addr - INST_BASE) >> 2;
        if (!hit_inst || acc.addr[1:0] != 2'b00) begin
          r.status = STAT_BAD;
        end else if (idx >= INST_WORDS) begin
          r.status = STAT_DEPTH;
        end
        if (acc.action == ACT_FETCH) begin
          if (r.status == STAT_OK) r.rdata = inst_mem[idx];
          else r.rdata = '1;
        end else if (r.status == STAT_OK) begin
          inst_mem[idx] = acc.wdata;
        end
      end else if (acc.size > SZ_WORD) begin
        r.status = STAT_BAD;
      end else begin
        nbytes = 1 << acc.size;
        lmask  = (nbytes == 4) ? 32'hFFFF_FFFF : ((32'h1 << (8 * nbytes)) - 1);
        is_wr  = (acc.action == ACT_WRITE);
        if ((acc.addr & (nbytes - 1)) != 0) begin
          r.status = STAT_BAD;
        end else begin
          // big-endian lanes: byte offset 0 sits in bits 31..24
          shift    = (4 - acc.addr[1:0] - nbytes) * 8;
          low_lane = (acc.addr[1:0] + nbytes == 4);
          if (hit_data || (hit_inst && !is_wr)) begin
            idx   = (acc.addr - (hit_data ? DATA_BASE : INST_BASE)) >> 2;
            depth = hit_data ? DATA_WORDS : INST_WORDS;
            if (idx >= depth) begin
              r.status = STAT_DEPTH;
            end else if (is_wr) begin
              data_mem[idx] = (data_mem[idx] & ~(lmask << shift)) |
                              ((acc.wdata & lmask) << shift);
            end else begin
              if (hit_data) word = data_mem[idx];
              else word = inst_mem[idx];
              r.rdata = (word >> shift) & lmask;
            end
          end else if (!is_wr && acc.addr[31:2] == CON_IN_ADDR[31:2]) begin
            // console input: all ones in the access width at end of input, else take the character
            if (acc.cons_eof) begin
              r.rdata = lmask;
            end else begin
              r.char_taken = 1'b1;
              r.rdata      = low_lane ? {24'h0, acc.cons_char} : 32'h0;
            end
          end else if (is_wr && acc.addr[31:2] == CON_OUT_ADDR[31:2]) begin
            r.char_valid = 1'b1;
            r.char_byte  = low_lane ? acc.wdata[7:0] : 8'h00;
          end else begin
            r.status = STAT_BAD;
          end
        end
      end
      return r;
    endfunction

    function void note_access(access_t acc);
      due_replies.push_back(map_access(acc));
    endfunction

    function void flag_error(string what, reply_t want, reply_t got);
      error_count++;
      if (error_count <= 10) begin
        $display("%0t reply error (%s): expected rd=%h cv=%b co=%h cc=%b st=%0d",
                 $time, what, want.rdata, want.char_valid, want.char_byte,
                 want.char_taken, want.status);
        $display("    got rd=%h cv=%b co=%h cc=%b st=%0d",
                 got.rdata, got.char_valid, got.char_byte, got.char_taken, got.status);
      end
    endfunction

    // Compare one reply beat with the oldest outstanding expectation
    function void check_reply(reply_t got);
      reply_t want;
      logic   bad;
      if (due_replies.size() == 0) begin
        flag_error("no access outstanding", '0, got);
        return;
      end
      want = due_replies.pop_front();
      bad  = 1'b0;
      if (got.rdata !== want.rdata) bad = 1'b1;
      if (got.char_valid !== want.char_valid) bad = 1'b1;
      if (got.char_byte !== want.char_byte) bad = 1'b1;
      if (got.char_taken !== want.char_taken) bad = 1'b1;
      if (got.status !== want.status) bad = 1'b1;
      if (bad) flag_error("field differs", want, got);
    endfunction
  endclass

endpackage

// ===== dv/mips_memory_map_access_tb.sv =====
`timescale 1ns / 1ps
module mips_memory_map_access_tb;
  import mma_pkg::*;
  import mma_tb_pkg::*;

  localparam int unsigned RANDOM_BEATS = 1650;
  localparam int unsigned IDLE_LIMIT   = 20000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned HOLD_AFTER   = 400;
  localparam int unsigned DATA_SPAN    = (DATA_END - DATA_BASE) / 4;
  localparam int unsigned INST_SPAN    = (INST_END - INST_BASE) / 4;

  typedef enum logic [1:0] {RX_FULL, RX_LIGHT, RX_HEAVY} rx_mode_e;

  logic        clk                = 1'b0;
  logic        rst_n              = 1'b0;
  logic        in_valid           = 1'b0;
  logic [1:0]  in_action          = ACT_READ;
  logic [1:0]  in_access_size     = SZ_BYTE;
  logic [31:0] in_address         = '0;
  logic [31:0] in_write_data      = '0;
  logic [7:0]  in_console_char    = '0;
  logic        in_console_eof     = 1'b0;
  logic        out_ready          = 1'b1;
  logic        in_ready;
  logic        out_valid;
  logic [31:0] out_read_data;
  logic        out_char_out_valid;
  logic [7:0]  out_char_out;
  logic        out_char_consumed;
  logic [1:0]  out_status;

  access_scoreboard sb;
  int unsigned      idle_cycles  = 0;
  int unsigned      replies_seen = 0;
  int unsigned      burst_left   = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  mips_memory_map_access u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_access_size    (in_access_size),
    .in_address        (in_address),
    .in_write_data     (in_write_data),
    .in_console_char   (in_console_char),
    .in_console_eof    (in_console_eof),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_data     (out_read_data),
    .out_char_out_valid(out_char_out_valid),
    .out_char_out      (out_char_out),
    .out_char_consumed (out_char_consumed),
    .out_status        (out_status)
  );

  // Check every reply beat
  always @(posedge clk) begin
    reply_t got;
    if (rst_n && out_valid && out_ready) begin
      got.rdata      = out_read_data;
      got.char_valid = out_char_out_valid;
      got.char_byte  = out_char_out;
      got.char_taken = out_char_consumed;
      got.status     = out_status;
      sb.check_reply(got);
      replies_seen++;
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("mips_memory_map_access: mismatch");
      $finish;
    end
  end

  // Reply side: runs of full rate, light and heavy stalls, one long hold-off
  initial begin
    rx_mode_e    mode;
    int unsigned mode_left;
    bit          held;
    mode      = RX_FULL;
    mode_left = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && replies_seen >= HOLD_AFTER) begin
        held      = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(4, 60);
      end
      mode_left--;
      case (mode)
        RX_FULL:  out_ready = 1'b1;
        RX_LIGHT: out_ready = ($urandom_range(0, 3) != 0);
        default:  out_ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic access_t mk(logic [1:0] act, logic [1:0] sz, logic [31:0] a,
                                 logic [31:0] wd = 32'h0, logic [7:0] ch = 8'h5A,
                                 logic eof = 1'b0);
    access_t acc;
    acc.action    = act;
    acc.size      = sz;
    acc.addr      = a;
    acc.wdata     = wd;
    acc.cons_char = ch;
    acc.cons_eof  = eof;
    return acc;
  endfunction

  // Offer one beat, hold it until accepted, then maybe open a gap
  task automatic issue(input access_t acc);
    in_valid        = 1'b1;
    in_action       = acc.action;
    in_access_size  = acc.size;
    in_address      = acc.addr;
    in_write_data   = acc.wdata;
    in_console_char = acc.cons_char;
    in_console_eof  = acc.cons_eof;
    do @(posedge clk); while (!in_ready);
    sb.note_access(acc);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(0, 20);
    end else begin
      burst_left--;
    end
  endtask

  // Random access: mostly well-formed hits in small windows so reads see writes
  function automatic access_t rand_access();
    access_t     acc;
    int unsigned pick;
    logic [1:0]  off;
    acc.action    = ($urandom_range(0, 1) != 0) ? ACT_WRITE : ACT_READ;
    acc.size      = 2'($urandom_range(0, 2));
    acc.wdata     = $urandom();
    acc.cons_char = 8'($urandom_range(0, 255));
    acc.cons_eof  = ($urandom_range(0, 4) == 0);
    off = 2'($urandom_range(0, 3));
    if (acc.size == SZ_HALF) off[0] = 1'b0;
    if (acc.size == SZ_WORD) off = 2'b00;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      acc.addr = DATA_BASE + ($urandom_range(0, 15) << 2) + off;
    end else if (pick < 38) begin
      acc.addr = DATA_BASE + ($urandom_range(0, DATA_WORDS - 1) << 2) + off;
    end else if (pick < 40) begin
      acc.addr = DATA_BASE + ($urandom_range(DATA_WORDS, DATA_SPAN - 1) << 2) + off;
    end else if (pick < 60) begin
      acc.action = ($urandom_range(0, 4) < 3) ? ACT_FETCH : ACT_LOAD;
      acc.size   = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0:       acc.addr = INST_BASE + ($urandom_range(0, 15) << 2) + $urandom_range(1, 3);
        1:       acc.addr = INST_BASE + ($urandom_range(INST_WORDS, INST_SPAN - 1) << 2);
        2:       acc.addr = INST_BASE + ($urandom_range(0, INST_WORDS - 1) << 2);
        default: acc.addr = INST_BASE + ($urandom_range(0, 15) << 2);
      endcase
    end else if (pick < 65) begin
      acc.action = ACT_READ;
      acc.addr   = INST_BASE + ($urandom_range(0, 15) << 2) + off;
    end else if (pick < 75) begin
      acc.action = ($urandom_range(0, 7) == 0) ? ACT_WRITE : ACT_READ;
      acc.addr   = CON_IN_ADDR + off;
    end else if (pick < 85) begin
      acc.action = ($urandom_range(0, 7) == 0) ? ACT_READ : ACT_WRITE;
      acc.addr   = CON_OUT_ADDR + off;
    end else if (pick < 92) begin
      acc.addr = DATA_BASE + ($urandom_range(0, 15) << 2) + $urandom_range(0, 3);
    end else if (pick < 95) begin
      acc.size = SZ_NONE;
      acc.addr = DATA_BASE + ($urandom_range(0, 15) << 2) + $urandom_range(0, 3);
    end else begin
      acc.action = 2'($urandom_range(0, 3));
      acc.size   = 2'($urandom_range(0, 3));
      acc.addr   = $urandom();
    end
    return acc;
  endfunction

  initial begin
    sb = new();
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed: lanes, masking, alignment, depth, fetch/load, console
    issue(mk(ACT_READ,  SZ_WORD, DATA_BASE));
    issue(mk(ACT_WRITE, SZ_WORD, DATA_BASE, 32'hDEAD_BEEF));
    issue(mk(ACT_WRITE, SZ_BYTE, DATA_BASE + 1, 32'hFFFF_FF00));
    issue(mk(ACT_WRITE, SZ_HALF, DATA_BASE + 2, 32'h1234_A55A));
    issue(mk(ACT_READ,  SZ_BYTE, DATA_BASE + 3));
    issue(mk(ACT_READ,  SZ_HALF, DATA_BASE));
    issue(mk(ACT_READ,  SZ_WORD, DATA_BASE));
    issue(mk(ACT_READ,  SZ_HALF, DATA_BASE + 1));
    issue(mk(ACT_WRITE, SZ_WORD, DATA_BASE + 2, 32'hFFFF_FFFF));
    issue(mk(ACT_READ,  SZ_NONE, DATA_BASE));
    issue(mk(ACT_WRITE, SZ_NONE, DATA_BASE, 32'hFFFF_FFFF));
    issue(mk(ACT_WRITE, SZ_WORD, DATA_BASE + (DATA_WORDS - 1) * 4, 32'hFFFF_FFFF));
    issue(mk(ACT_READ,  SZ_BYTE, DATA_BASE + DATA_WORDS * 4));
    issue(mk(ACT_WRITE, SZ_WORD, DATA_END - 4, 32'h8000_0001));
    issue(mk(ACT_LOAD,  SZ_WORD, INST_BASE, 32'hFFFF_FFFF));
    issue(mk(ACT_FETCH, SZ_BYTE, INST_BASE));
    issue(mk(ACT_FETCH, SZ_WORD, INST_BASE + 2));
    issue(mk(ACT_FETCH, SZ_WORD, DATA_BASE));
    issue(mk(ACT_LOAD,  SZ_WORD, INST_BASE + INST_WORDS * 4, 32'h1));
    issue(mk(ACT_FETCH, SZ_WORD, INST_END - 4));
    issue(mk(ACT_WRITE, SZ_WORD, INST_BASE, 32'h0));
    issue(mk(ACT_READ,  SZ_BYTE, INST_BASE));
    issue(mk(ACT_READ,  SZ_BYTE, CON_IN_ADDR + 3, 32'h0, 8'hFF));
    issue(mk(ACT_READ,  SZ_HALF, CON_IN_ADDR, 32'h0, 8'h41));
    issue(mk(ACT_READ,  SZ_WORD, CON_IN_ADDR, 32'h0, 8'h00, 1'b1));
    issue(mk(ACT_WRITE, SZ_BYTE, CON_OUT_ADDR + 3, 32'hFFFF_FFA5));
    issue(mk(ACT_WRITE, SZ_HALF, CON_OUT_ADDR, 32'hFFFF_FFFF));
    issue(mk(ACT_WRITE, SZ_WORD, CON_IN_ADDR, 32'h7));
    issue(mk(ACT_READ,  SZ_WORD, CON_OUT_ADDR));
    issue(mk(ACT_READ,  SZ_BYTE, 32'hFFFF_FFFF));

    // Random traffic
    repeat (RANDOM_BEATS) issue(rand_access());
    in_valid = 1'b0;

    // Drain outstanding replies, then allow for stray beats
    while (sb.due_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.error_count == 0 && sb.due_replies.size() == 0) begin
      $display("mips_memory_map_access: match");
    end else begin
      $display("mips_memory_map_access: mismatch");
    end
    $finish;
  end

endmodule
